FILE: rtl/rk4s_pkg.sv
// Shared types and constants for the fixed-point RK4 step block.
package rk4s_pkg;

  // Field widths
  localparam int unsigned STEP_W = 23;
  localparam int unsigned IVL_W  = 31;
  localparam int unsigned TIME_W = 31;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned TACC_W = 32;

  // Datapath widths
  localparam int unsigned PROD_W = 56;
  localparam int unsigned ACC_W  = 59;
  localparam int unsigned SAT_W  = 64;

  // Divide-by-three unit: DIV_DIGIT quotient bits per cycle
  localparam int unsigned DIV_W      = 64;
  localparam int unsigned DIV_DIGIT  = 8;
  localparam int unsigned DIV_CYCLES = DIV_W / DIV_DIGIT;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES);

  // Register port
  localparam int unsigned ADDR_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W  = 3;

  localparam logic [IDX_W-1:0] REG_STEP_SIZE       = 3'd0;
  localparam logic [IDX_W-1:0] REG_SAMPLE_INTERVAL = 3'd1;
  localparam logic [IDX_W-1:0] REG_END_TIME        = 3'd2;
  localparam logic [IDX_W-1:0] REG_INITIAL_Y       = 3'd3;
  localparam logic [IDX_W-1:0] REG_INITIAL_Z       = 3'd4;

  localparam logic [STEP_W-1:0]        RST_STEP_SIZE       = 23'd20972;
  localparam logic [IVL_W-1:0]         RST_SAMPLE_INTERVAL = 31'd838861;
  localparam logic [TIME_W-1:0]        RST_END_TIME        = 31'd8388608;
  localparam logic signed [VAL_W-1:0]  RST_INITIAL_Y       = 32'sd12582912;
  localparam logic signed [VAL_W-1:0]  RST_INITIAL_Z       = 32'sd16777216;

  typedef struct packed {
    logic [STEP_W-1:0]       step_size;
    logic [IVL_W-1:0]        sample_interval;
    logic [TIME_W-1:0]       end_time;
    logic signed [VAL_W-1:0] initial_y;
    logic signed [VAL_W-1:0] initial_z;
  } cfg_t;

  typedef struct packed {
    logic                    valid;
    logic [TIME_W-1:0]       time_now;
    logic signed [VAL_W-1:0] y_now;
    logic signed [VAL_W-1:0] z_now;
    logic                    done_res;
  } res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DERIV,
    ST_MULC,
    ST_RNDC,
    ST_UPDZ,
    ST_ABSY,
    ST_DIVY,
    ST_WAITY,
    ST_WAITZ
  } rk4s_state_e;

endpackage

FILE: rtl/rk4s_mul.sv
// Shared step-size multiplier with registered product.
module rk4s_mul import rk4s_pkg::*; (
  input  logic                     clk_i,
  input  logic [STEP_W-1:0]        step_i,
  input  logic signed [VAL_W-1:0]  opnd_i,
  output logic signed [PROD_W-1:0] prod_o
);

  logic signed [STEP_W:0]  h_s;
  logic signed [PROD_W-1:0] prod_q;

  assign h_s = signed'({1'b0, step_i});

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(h_s) * PROD_W'(opnd_i);
  end

  assign prod_o = prod_q;

endmodule

FILE: rtl/rk4s_div3.sv
// Rounded divide by 3*2^(FRAC_BITS+1), one quotient byte per cycle.
module rk4s_div3 import rk4s_pkg::*; #(
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] mag_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quo_o
);

  localparam logic [DIV_W-1:0]     ROUND   = DIV_W'(3) << FRAC_BITS;
  localparam logic [2:0]           DIVISOR = 3'd3;
  localparam logic [DIV_CNT_W-1:0] LAST    = DIV_CNT_W'(DIV_CYCLES - 1);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     work_q;
  logic [1:0]           rem_q;

  logic [DIV_W-1:0]     loaded;
  logic [DIV_DIGIT-1:0] chunk;
  logic [DIV_DIGIT-1:0] qdig;
  logic [1:0]           rem_n;
  logic [2:0]           trial;

  // Add half the divisor, then drop the power-of-two part of the divisor.
  assign loaded = (mag_i + ROUND) >> (FRAC_BITS + 1);

  // Long division by three over the top byte; quotient bits enter at the bottom.
  always_comb begin
    rem_n = rem_q;
    chunk = work_q[DIV_W-1 -: DIV_DIGIT];
    qdig  = '0;
    for (int i = DIV_DIGIT - 1; i >= 0; i--) begin
      trial = {rem_n, chunk[i]};
      if (trial >= DIVISOR) begin
        qdig[i] = 1'b1;
        rem_n   = 2'(trial - DIVISOR);
      end else begin
        qdig[i] = 1'b0;
        rem_n   = trial[1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      work_q <= loaded;
      rem_q  <= '0;
    end else if (busy_q) begin
      work_q <= {work_q[DIV_W-DIV_DIGIT-1:0], qdig};
      rem_q  <= rem_n;
    end
  end

  assign done_o = done_q;
  assign quo_o  = work_q;

endmodule

FILE: rtl/rk4s_core.sv
// Tick sequencer and datapath: sample check, four RK stages, final update.
module rk4s_core import rk4s_pkg::*; #(
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic start_i,
  input  logic restart_i,
  input  logic res_take_i,
  output logic busy_o,
  output res_t res_o
);

  localparam logic [1:0] STAGE_FIRST = 2'd0;
  localparam logic [1:0] STAGE_B     = 2'd1;
  localparam logic [1:0] STAGE_C     = 2'd2;
  localparam logic [1:0] STAGE_LAST  = 2'd3;

  localparam logic signed [PROD_W-1:0] BIAS_HALF = PROD_W'(64'd1 << FRAC_BITS);
  localparam logic signed [PROD_W-1:0] BIAS_FULL = PROD_W'(64'd1 << (FRAC_BITS - 1));
  localparam logic signed [SAT_W-1:0]  SAT_MAX   = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [SAT_W-1:0]  SAT_MIN   = 64'shFFFF_FFFF_8000_0000;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [SAT_W-1:0] v);
    logic signed [VAL_W-1:0] r;
    if (v > SAT_MAX) begin
      r = VAL_W'(SAT_MAX);
    end else if (v < SAT_MIN) begin
      r = VAL_W'(SAT_MIN);
    end else begin
      r = VAL_W'(v);
    end
    return r;
  endfunction

  function automatic logic signed [VAL_W-1:0] deriv_z(input logic signed [VAL_W-1:0] y,
                                                       input logic signed [VAL_W-1:0] z);
    logic signed [SAT_W-1:0] yy;
    logic signed [SAT_W-1:0] zz;
    yy = SAT_W'(y);
    zz = SAT_W'(z);
    return sat_val((zz <<< 1) + zz - (yy <<< 1));
  endfunction

  rk4s_state_e state_q, state_d;
  logic [1:0]  stage_q, stage_d;

  logic signed [VAL_W-1:0] y_q, y_d, z_q, z_d;
  logic [TACC_W-1:0]       t_q, t_d, ns_q, ns_d;
  logic                    fin_q, fin_d;
  res_t                    res_q, res_d;

  logic signed [VAL_W-1:0]  ys_q, ys_d, zs_q, zs_d, c_q, c_d, ynew_q, ynew_d;
  logic signed [PROD_W-1:0] rq_q, rq_d;
  logic signed [ACC_W-1:0]  acc_y_q, acc_y_d, acc_z_q, acc_z_d;
  logic [DIV_W-1:0]         mag_q, mag_d;

  // Tick entry
  logic signed [VAL_W-1:0] eff_y, eff_z;
  logic [TACC_W-1:0]       eff_t, eff_ns;
  logic                    eff_fin;
  logic [TACC_W:0]         ns_sum;

  // Shared units
  logic signed [VAL_W-1:0]  mul_a;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rbias;
  logic signed [PROD_W-1:0] rsum;
  logic signed [ACC_W-1:0]  prod_w;
  logic                     dbl;
  logic                     div_start;
  logic                     div_done;
  logic [DIV_W-1:0]         div_quo;
  logic signed [SAT_W-1:0]  quo_s;
  logic signed [SAT_W-1:0]  upd_sum;

  assign mul_a = (state_q == ST_MULC) ? c_q : zs_q;

  rk4s_mul u_mul (
    .clk_i  (clk_i),
    .step_i (cfg_i.step_size),
    .opnd_i (mul_a),
    .prod_o (prod)
  );

  assign div_start = (state_q == ST_DIVY) || ((state_q == ST_WAITY) && div_done);

  rk4s_div3 #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .mag_i   (mag_q),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Round to nearest, ties away from zero: bias is one less for negative products.
  assign rbias  = (stage_q == STAGE_C) ? BIAS_FULL : BIAS_HALF;
  assign rsum   = prod + rbias - PROD_W'(prod[PROD_W-1]);
  assign prod_w = ACC_W'(prod);
  assign dbl    = (stage_q == STAGE_B) || (stage_q == STAGE_C);
  assign quo_s  = signed'(div_quo);

  assign eff_t   = restart_i ? '0 : t_q;
  assign eff_ns  = restart_i ? '0 : ns_q;
  assign eff_fin = restart_i ? 1'b0 : fin_q;
  assign eff_y   = restart_i ? cfg_i.initial_y : y_q;
  assign eff_z   = restart_i ? cfg_i.initial_z : z_q;
  assign ns_sum  = {1'b0, eff_ns} + (TACC_W + 1)'(cfg_i.sample_interval);

  always_comb begin
    state_d = state_q;
    stage_d = stage_q;
    y_d     = y_q;
    z_d     = z_q;
    t_d     = t_q;
    ns_d    = ns_q;
    fin_d   = fin_q;
    res_d   = res_q;
    ys_d    = ys_q;
    zs_d    = zs_q;
    c_d     = c_q;
    rq_d    = rq_q;
    acc_y_d = acc_y_q;
    acc_z_d = acc_z_q;
    mag_d   = mag_q;
    ynew_d  = ynew_q;
    upd_sum = '0;

    if (res_take_i) begin
      res_d.valid = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          t_d     = eff_t;
          ns_d    = eff_ns;
          fin_d   = eff_fin;
          y_d     = eff_y;
          z_d     = eff_z;
          ys_d    = eff_y;
          zs_d    = eff_z;
          stage_d = STAGE_FIRST;
          acc_y_d = '0;
          acc_z_d = '0;
          if (eff_fin) begin
            res_d.valid    = 1'b1;
            res_d.time_now = '0;
            res_d.y_now    = '0;
            res_d.z_now    = '0;
            res_d.done_res = 1'b1;
          end else begin
            if (eff_t >= eff_ns) begin
              ns_d           = ns_sum[TACC_W] ? '1 : ns_sum[TACC_W-1:0];
              res_d.valid    = 1'b1;
              res_d.time_now = eff_t[TIME_W-1:0];
              res_d.y_now    = eff_y;
              res_d.z_now    = eff_z;
              res_d.done_res = 1'b0;
            end
            state_d = ST_DERIV;
          end
        end
      end
      // Multiplier takes h*b while the stage derivative is formed.
      ST_DERIV: begin
        c_d     = deriv_z(ys_q, zs_q);
        state_d = ST_MULC;
      end
      ST_MULC: begin
        acc_y_d = acc_y_q + (dbl ? (prod_w <<< 1) : prod_w);
        rq_d    = (stage_q == STAGE_C) ? (rsum >>> FRAC_BITS) : (rsum >>> (FRAC_BITS + 1));
        state_d = ST_RNDC;
      end
      ST_RNDC: begin
        acc_z_d = acc_z_q + (dbl ? (prod_w <<< 1) : prod_w);
        ys_d    = sat_val(SAT_W'(y_q) + SAT_W'(rq_q));
        rq_d    = (stage_q == STAGE_C) ? (rsum >>> FRAC_BITS) : (rsum >>> (FRAC_BITS + 1));
        state_d = (stage_q == STAGE_LAST) ? ST_ABSY : ST_UPDZ;
      end
      ST_UPDZ: begin
        zs_d    = sat_val(SAT_W'(z_q) + SAT_W'(rq_q));
        stage_d = stage_q + 2'd1;
        state_d = ST_DERIV;
      end
      ST_ABSY: begin
        mag_d   = DIV_W'(acc_y_q[ACC_W-1] ? -acc_y_q : acc_y_q);
        state_d = ST_DIVY;
      end
      ST_DIVY: begin
        mag_d   = DIV_W'(acc_z_q[ACC_W-1] ? -acc_z_q : acc_z_q);
        state_d = ST_WAITY;
      end
      ST_WAITY: begin
        if (div_done) begin
          upd_sum = acc_y_q[ACC_W-1] ? (SAT_W'(y_q) - quo_s) : (SAT_W'(y_q) + quo_s);
          ynew_d  = sat_val(upd_sum);
          state_d = ST_WAITZ;
        end
      end
      ST_WAITZ: begin
        if (div_done) begin
          upd_sum = acc_z_q[ACC_W-1] ? (SAT_W'(z_q) - quo_s) : (SAT_W'(z_q) + quo_s);
          z_d     = sat_val(upd_sum);
          y_d     = ynew_q;
          t_d     = t_q + TACC_W'(cfg_i.step_size);
          fin_d   = t_d > TACC_W'(cfg_i.end_time);
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      stage_q <= STAGE_FIRST;
      y_q     <= RST_INITIAL_Y;
      z_q     <= RST_INITIAL_Z;
      t_q     <= '0;
      ns_q    <= '0;
      fin_q   <= 1'b0;
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      stage_q <= stage_d;
      y_q     <= y_d;
      z_q     <= z_d;
      t_q     <= t_d;
      ns_q    <= ns_d;
      fin_q   <= fin_d;
      res_q   <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ys_q    <= ys_d;
    zs_q    <= zs_d;
    c_q     <= c_d;
    rq_q    <= rq_d;
    acc_y_q <= acc_y_d;
    acc_z_q <= acc_z_d;
    mag_q   <= mag_d;
    ynew_q  <= ynew_d;
  end

  assign busy_o = (state_q != ST_IDLE);
  assign res_o  = res_q;

endmodule

FILE: rtl/rk4_second_order_ode_step.sv
// Top level: register port, tick handshake and output register of the RK4 stepper.
//
//   channel  direction  handshake                     payload
//   in       input      in_valid_i / in_stall_o       restart_i
//   out      output     out_valid_o / out_stall_i     time_now_o, y_now_o, z_now_o, done_res_o
//   cfg      input      psel, penable, pwrite, pready paddr, pwdata, prdata
//
// A tick that steps runs the sequencer through the four RK stages around the shared
// step-size multiplier, then makes two passes through the divide-by-3 unit.
// A tick after the run has ended steps nothing; the next tick waits for its result to move on.
// A result beat moves to the output register as soon as it is free, so one result may
// wait under out_stall_i while the next tick is accepted.
// Reset restores the register defaults, time zero and the default start values.
module rk4_second_order_ode_step import rk4s_pkg::*; #(
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    restart_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [TIME_W-1:0]       time_now_o,
  output logic signed [VAL_W-1:0] y_now_o,
  output logic signed [VAL_W-1:0] z_now_o,
  output logic                    done_res_o,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready
);

  cfg_t             cfg_q;
  logic [IDX_W-1:0] reg_idx;
  logic             cfg_wr;

  logic start;
  logic busy;
  logic take;
  res_t res;

  logic                    out_valid_q;
  logic [TIME_W-1:0]       time_now_q;
  logic signed [VAL_W-1:0] y_now_q;
  logic signed [VAL_W-1:0] z_now_q;
  logic                    done_res_q;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_size       <= RST_STEP_SIZE;
      cfg_q.sample_interval <= RST_SAMPLE_INTERVAL;
      cfg_q.end_time        <= RST_END_TIME;
      cfg_q.initial_y       <= RST_INITIAL_Y;
      cfg_q.initial_z       <= RST_INITIAL_Z;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_STEP_SIZE:       cfg_q.step_size       <= pwdata[STEP_W-1:0];
        REG_SAMPLE_INTERVAL: cfg_q.sample_interval <= pwdata[IVL_W-1:0];
        REG_END_TIME:        cfg_q.end_time        <= pwdata[TIME_W-1:0];
        REG_INITIAL_Y:       cfg_q.initial_y       <= signed'(pwdata[VAL_W-1:0]);
        REG_INITIAL_Z:       cfg_q.initial_z       <= signed'(pwdata[VAL_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_STEP_SIZE:       prdata = DATA_W'(cfg_q.step_size);
      REG_SAMPLE_INTERVAL: prdata = DATA_W'(cfg_q.sample_interval);
      REG_END_TIME:        prdata = DATA_W'(cfg_q.end_time);
      REG_INITIAL_Y:       prdata = DATA_W'(unsigned'(cfg_q.initial_y));
      REG_INITIAL_Z:       prdata = DATA_W'(unsigned'(cfg_q.initial_z));
      default:             prdata = '0;
    endcase
  end

  // Hold off ticks while stepping or while a result beat still waits for the output slot.
  assign in_stall_o = busy || res.valid;
  assign start      = in_valid_i && !in_stall_o;

  rk4s_core #(
    .FRAC_BITS (FRAC_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .start_i    (start),
    .restart_i  (restart_i),
    .res_take_i (take),
    .busy_o     (busy),
    .res_o      (res)
  );

  assign take = res.valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      time_now_q <= res.time_now;
      y_now_q    <= res.y_now;
      z_now_q    <= res.z_now;
      done_res_q <= res.done_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign time_now_o  = time_now_q;
  assign y_now_o     = y_now_q;
  assign z_now_o     = z_now_q;
  assign done_res_o  = done_res_q;

endmodule
